>>> hdl/ibt_pkg.sv
// shared types and constants for the input binding table
package ibt_pkg;

  localparam int DEFAULT_TABLE_DEPTH  = 64;
  localparam int DEFAULT_HANDLER_BITS = 16;

  localparam int KIND_W    = 3;
  localparam int CODE_W    = 8;
  localparam int MODS_W    = 16;
  localparam int AREA_W    = 4;
  localparam int KEY_W     = KIND_W + CODE_W + MODS_W + AREA_W;
  localparam int HFIELD_W  = 16;
  localparam int LOOKUP_MODS_W = 8;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [MODS_W-1:0] ANY_MODIFIER = 16'h8000;
  localparam logic [CODE_W-1:0] WILD_CODE    = 8'h00;
  localparam logic [AREA_W-1:0] NO_AREA      = 4'h0;
  localparam logic [7:0]        IGNORE_MASK_RESET = 8'h02;

  // same bit layout as a stored key: kind, code, modifiers, area
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [MODS_W-1:0] mods;
    logic [AREA_W-1:0] area;
  } key_t;

  typedef struct packed {
    logic start;
    logic rd_valid;
    logic wild;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic free_found;
  } scan_flags_t;

endpackage

>>> hdl/ibt_ram.sv
// generic single write, single read ram with registered read data
module ibt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ibt_match.sv
// compares each scanned entry with the probe keys and keeps the best hit and first free slot
module ibt_match #(
  parameter int AW = 6,
  parameter int HB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ibt_pkg::scan_ctl_t   ctl,
  input  ibt_pkg::key_t        req_key,
  input  logic [AW-1:0]        rd_idx,
  input  logic                 ent_valid,
  input  ibt_pkg::key_t        ent_key,
  input  logic [HB-1:0]        ent_handler,
  output ibt_pkg::scan_flags_t flags,
  output logic [2:0]           best_prio,
  output logic [AW-1:0]        best_idx,
  output logic [HB-1:0]        best_handler,
  output logic [AW-1:0]        free_idx
);
  import ibt_pkg::*;

  logic       found;
  logic       free_found;
  logic       c_ex, c_wd, m_ex, m_any, a_ex, a_zero, kind_ok;
  logic       match;
  logic [2:0] prio;

  always_comb begin
    kind_ok = ent_key.kind == req_key.kind;
    c_ex    = ent_key.code == req_key.code;
    c_wd    = ent_key.code == WILD_CODE;
    m_ex    = ent_key.mods == req_key.mods;
    m_any   = ent_key.mods == ANY_MODIFIER;
    a_ex    = ent_key.area == req_key.area;
    a_zero  = ent_key.area == NO_AREA;
    if (ctl.wild) begin
      // probe order: area given before area zero, then code, then modifiers
      match = ent_valid && kind_ok && (c_ex || c_wd) && (m_ex || m_any) && (a_ex || a_zero);
      prio  = {!a_ex, !c_ex, !m_ex};
    end else begin
      match = ent_valid && kind_ok && c_ex && m_ex && a_ex;
      prio  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.rd_valid) begin
      if (match && (!found || prio < best_prio)) begin
        found        <= 1'b1;
        best_prio    <= prio;
        best_idx     <= rd_idx;
        best_handler <= ent_handler;
      end
      if (!ent_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  assign flags = '{hit: found, free_found: free_found};

endmodule

>>> hdl/input_binding_table_lookup.sv
// input binding table: add, remove and wildcard lookup of key bindings
//
// Items enter on in_valid/in_stall; an item is taken when in_valid is high
// and in_stall is low. mode selects add, remove or lookup. Every item gives
// exactly one result on out_valid/out_stall (status, handler_out, probe_hit).
// Each item sweeps the whole binding ram once, one entry per cycle, as the
// ram has a single read port. in_stall stays high until the result is in
// the output register, so no new item is taken before the last one is done.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and its result is held back until
// the register frees up.
// After reset the ram is swept once to clear its valid marks, in_stall high.
// The ignore_mask register (reset 0x02) is written over cfg_valid/cfg_ready/
// cfg_data; the user must do so only while the block is idle (not enforced).
module input_binding_table_lookup #(
  parameter int TABLE_DEPTH  = ibt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int HANDLER_BITS = ibt_pkg::DEFAULT_HANDLER_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [2:0]  event_kind,
  input  logic [15:0] modifiers,
  input  logic [7:0]  code,
  input  logic [3:0]  area,
  input  logic [15:0] handler_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] handler_out,
  output logic [2:0]  probe_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import ibt_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = 1 + KEY_W + HANDLER_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state;

  logic [7:0]              ignore_mask;
  logic [AW-1:0]           addr;
  logic                    rd_pend;
  logic [AW-1:0]           rd_idx;
  logic [1:0]              req_mode;
  key_t                    req_key;
  logic [HANDLER_BITS-1:0] req_handler;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [ENTRY_W-1:0]      wdata;
  logic [ENTRY_W-1:0]      rdata;

  scan_ctl_t               ctl;
  scan_flags_t             flags;
  logic [2:0]              best_prio;
  logic [AW-1:0]           best_idx;
  logic [HANDLER_BITS-1:0] best_handler;
  logic [AW-1:0]           free_idx;

  logic                    accept;
  logic                    out_free;
  logic                    commit;
  logic                    commit_we;
  logic [AW-1:0]           commit_addr;
  logic                    commit_valid;
  logic [1:0]              res_status;
  logic [15:0]             res_handler;
  logic [2:0]              res_probe;
  logic [31:0]             hin_ext;
  logic [31:0]             hout_ext;
  logic [LOOKUP_MODS_W-1:0] lookup_mods;

  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign commit    = state == ST_COMMIT && out_free;

  assign hin_ext     = 32'(handler_in);
  assign hout_ext    = 32'(best_handler);
  assign lookup_mods = modifiers[LOOKUP_MODS_W-1:0] & ~ignore_mask;

  assign ctl = '{start: accept, rd_valid: rd_pend, wild: req_mode == MODE_LOOKUP};

  ibt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  ibt_match #(
    .AW (AW),
    .HB (HANDLER_BITS)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .req_key      (req_key),
    .rd_idx       (rd_idx),
    .ent_valid    (rdata[ENTRY_W-1]),
    .ent_key      (key_t'(rdata[ENTRY_W-2 -: KEY_W])),
    .ent_handler  (rdata[HANDLER_BITS-1:0]),
    .flags        (flags),
    .best_prio    (best_prio),
    .best_idx     (best_idx),
    .best_handler (best_handler),
    .free_idx     (free_idx)
  );

  // result and write-back decided after the sweep
  always_comb begin
    commit_we    = 1'b0;
    commit_addr  = best_idx;
    commit_valid = 1'b1;
    res_status   = STATUS_NOTFOUND;
    res_handler  = '0;
    res_probe    = '0;
    unique case (req_mode)
      MODE_ADD: begin
        if (flags.hit) begin
          commit_we  = 1'b1;
          res_status = STATUS_OK;
        end else if (flags.free_found) begin
          commit_we   = 1'b1;
          commit_addr = free_idx;
          res_status  = STATUS_OK;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      MODE_REMOVE: begin
        if (flags.hit) begin
          commit_we    = 1'b1;
          commit_valid = 1'b0;
          res_status   = STATUS_OK;
        end
      end
      MODE_LOOKUP: begin
        if (flags.hit) begin
          res_status  = STATUS_OK;
          res_handler = hout_ext[15:0];
          res_probe   = best_prio;
        end
      end
      default: begin
        res_status = STATUS_NOTFOUND;
      end
    endcase
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = addr;
      wdata = '0;
    end else begin
      we    = commit && commit_we;
      waddr = commit_addr;
      wdata = {commit_valid, req_key, req_handler};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      addr        <= '0;
      rd_pend     <= 1'b0;
      ignore_mask <= IGNORE_MASK_RESET;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= state == ST_SCAN;
      rd_idx  <= addr;
      if (cfg_valid && cfg_ready) begin
        ignore_mask <= cfg_data;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (addr == LAST_ADDR) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_mode     <= mode;
            req_key.kind <= event_kind;
            req_key.code <= code;
            req_key.area <= area;
            req_handler  <= hin_ext[HANDLER_BITS-1:0];
            if (mode == MODE_LOOKUP) begin
              req_key.mods <= MODS_W'(lookup_mods);
            end else begin
              req_key.mods <= modifiers;
            end
            addr  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr == LAST_ADDR) begin
            addr  <= '0;
            state <= ST_DRAIN;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            status      <= res_status;
            handler_out <= res_handler;
            probe_hit   <= res_probe;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/ibt_checker.sv
// port-level checks for the input binding table, bound to the top level
module ibt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] handler_out,
  input logic [2:0]  probe_hit
);
  import ibt_pkg::*;

  // one transaction at a time: the sweep blocks the input right away
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> handler_out == '0 && probe_hit == '0)
    else $error("failed transaction carries a handler or probe");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(handler_out)
                               && $stable(probe_hit))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_OK || status == STATUS_NOTFOUND || status == STATUS_FULL)
    else $error("unknown status code");

endmodule

bind input_binding_table_lookup ibt_checker u_ibt_checker (.*);
